// ===== sv/ffa_pkg.sv =====
`default_nettype none

package ffa_pkg;

  localparam int unsigned SPLIT_SLACK = 16;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_BYTES = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] length;
    logic        free;
  } seg_t;

endpackage

`default_nettype wire

// ===== sv/ffa_ram.sv =====
`default_nettype none

module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/first_fit_heap_allocator_top.sv =====
// Channel   Direction  Handshake              Word
// input     in         in_valid / in_ready    op, request_bytes, free_address
// output    out        out_valid / out_ready  address, status, used_bytes, free_bytes
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// One word walks the segment table one entry per cycle through a single RAM read port,
// so a request scans up to the index of the matching entry, then shifts each entry moved
// by a split or a merge. The scan and the shift together cover the table once. After
// reset or any configuration write, the S_INIT state rebuilds the table before in_ready
// rises. A stalled result holds in the output register; the next word can be accepted
// while it waits.
`default_nettype none

module first_fit_heap_allocator_top
  import ffa_pkg::*;
#(
  parameter int HEADER_BYTES = 12,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        op,
  input  wire logic [31:0] request_bytes,
  input  wire logic [31:0] free_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      address,
  output logic [1:0]       status,
  output logic [31:0]      used_bytes,
  output logic [31:0]      free_bytes,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = IW + 1;
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
  localparam logic [CW-1:0] ONE = CW'(1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SCAN, S_FNEXT, S_MERGEW, S_SHDN,
    S_SPREP, S_SHUP, S_TAILW, S_HEADW, S_DONE
  } state_t;

  state_t      state;
  logic [31:0] heap_base;
  logic [31:0] heap_bytes;
  logic        op_r;
  logic [31:0] req_r;
  logic [31:0] faddr_r;
  logic [CW-1:0] idx;
  logic [CW-1:0] count;
  logic [CW-1:0] tgt;
  logic [CW-1:0] sp;
  logic [CW-1:0] wp;
  logic [1:0]  drop;
  logic [31:0] biu;
  seg_t        prev;
  logic [31:0] cur_off;
  logic [31:0] cur_len;
  logic [31:0] hlen;
  logic [31:0] toff;
  logic [31:0] mlen;
  logic [31:0] addr_r;
  status_t     st_r;

  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  seg_t              ram_wdata;
  logic [CW-1:0]     ram_raddr;
  logic [$bits(seg_t)-1:0] ram_rdata;
  seg_t              cur;
  logic [31:0]       paddr;
  logic              fit;
  logic              split;
  logic              nf;
  logic              pf;
  logic [CW-1:0]     src;
  logic [31:0]       init_len;

  ffa_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_SEGMENTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr[IW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr[IW-1:0]),
    .rdata (ram_rdata)
  );

  assign cur      = seg_t'(ram_rdata);
  assign paddr    = heap_base + cur.offset + HDR;
  assign fit      = cur.free && (cur.length >= req_r);
  assign split    = ({1'b0, cur.length} > ({1'b0, req_r} + 33'(HDR) + 33'(SPLIT_SLACK)))
                    && (count < MAXC);
  assign nf       = ((idx + ONE) < count) && cur.free;
  assign pf       = (idx != '0) && prev.free;
  assign src      = tgt + ONE + CW'(drop);
  assign init_len = (heap_bytes >= HDR) ? heap_bytes - HDR : 32'd0;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    ram_raddr = '0;
    case (state)
      S_SCAN:   ram_raddr = idx + ONE;
      S_MERGEW: ram_raddr = src;
      S_SHDN:   ram_raddr = sp + ONE;
      S_SPREP:  ram_raddr = count - ONE;
      S_SHUP:   ram_raddr = wp - CW'(2);
      default:  ram_raddr = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = '{offset: 32'd0, length: init_len, free: 1'b1};
      end
      S_MERGEW: begin
        ram_we    = 1'b1;
        ram_waddr = tgt;
        ram_wdata = '{offset: toff, length: mlen, free: 1'b1};
      end
      S_SHDN, S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = wp;
        ram_wdata = cur;
      end
      S_TAILW: begin
        ram_we    = 1'b1;
        ram_waddr = idx + ONE;
        ram_wdata = '{offset: cur_off + HDR + req_r, length: cur_len - req_r - HDR,
                      free: 1'b1};
      end
      S_HEADW: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = '{offset: cur_off, length: hlen, free: 1'b0};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      heap_base  <= 32'd0;
      heap_bytes <= 32'd1048576;
      count      <= ONE;
      biu        <= 32'd0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        if (reg_index_t'(cfg_index) == REG_HEAP_BASE) begin
          heap_base <= cfg_wdata;
        end else begin
          heap_bytes <= cfg_wdata;
        end
        state <= S_INIT;
      end else begin
        case (state)
          S_INIT: begin
            count <= ONE;
            biu   <= 32'd0;
            state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid) begin
              op_r    <= op;
              req_r   <= request_bytes;
              faddr_r <= free_address;
              idx     <= '0;
              addr_r  <= 32'd0;
              st_r    <= ST_DONE;
              if (op_t'(op) == OP_FREE && free_address == 32'd0) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            if (idx == count) begin
              st_r  <= (op_t'(op_r) == OP_ALLOC) ? ST_NOMEM : ST_INVALID;
              state <= S_DONE;
            end else if (op_t'(op_r) == OP_ALLOC) begin
              if (fit) begin
                cur_off <= cur.offset;
                cur_len <= cur.length;
                hlen    <= split ? req_r : cur.length;
                biu     <= biu + (split ? req_r : cur.length) + HDR;
                addr_r  <= paddr;
                state   <= split ? S_SPREP : S_HEADW;
              end else begin
                idx <= idx + ONE;
              end
            end else if (paddr == faddr_r) begin
              if (cur.free) begin
                st_r  <= ST_INVALID;
                state <= S_DONE;
              end else begin
                cur_off <= cur.offset;
                cur_len <= cur.length;
                biu     <= biu - cur.length - HDR;
                mlen    <= pf ? prev.length + cur.length + HDR : cur.length;
                toff    <= pf ? prev.offset : cur.offset;
                tgt     <= pf ? idx - ONE : idx;
                drop    <= pf ? 2'd1 : 2'd0;
                state   <= S_FNEXT;
              end
            end else begin
              prev <= cur;
              idx  <= idx + ONE;
            end
          end
          S_FNEXT: begin
            if (nf) begin
              mlen <= mlen + cur.length + HDR;
              drop <= drop + 2'd1;
            end
            state <= S_MERGEW;
          end
          S_MERGEW: begin
            if (drop != 2'd0 && src < count) begin
              sp    <= src;
              wp    <= tgt + ONE;
              state <= S_SHDN;
            end else begin
              count <= count - CW'(drop);
              state <= S_DONE;
            end
          end
          S_SHDN: begin
            if (sp == count - ONE) begin
              count <= count - CW'(drop);
              state <= S_DONE;
            end else begin
              sp <= sp + ONE;
              wp <= wp + ONE;
            end
          end
          S_SPREP: begin
            wp    <= count;
            state <= (count == idx + ONE) ? S_TAILW : S_SHUP;
          end
          S_SHUP: begin
            if (wp == idx + CW'(2)) begin
              state <= S_TAILW;
            end else begin
              wp <= wp - ONE;
            end
          end
          S_TAILW: begin
            count <= count + ONE;
            state <= S_HEADW;
          end
          S_HEADW: begin
            state <= S_DONE;
          end
          S_DONE: begin
            if (!out_valid || out_ready) begin
              out_valid  <= 1'b1;
              address    <= addr_r;
              status     <= st_r;
              used_bytes <= biu;
              free_bytes <= (heap_bytes >= biu) ? heap_bytes - biu : 32'd0;
              state      <= S_IDLE;
            end
          end
          default: state <= S_INIT;
        endcase
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count >= ONE) && (count <= MAXC))
    else $error("segment count out of range");

  a_cfg_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken while table is rebuilt");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_we) |=> !in_ready)
    else $error("second word taken while a request is in progress");

  a_free_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_TAILW) |-> (count < MAXC))
    else $error("split with a full table");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ffa_pkg::*;

  localparam int HDR  = 12;
  localparam int NSEG = 64;

  typedef enum int { K_ALLOC, K_LIVE, K_DOUBLE, K_RAND, K_NULL, K_FIXED } kind_t;

  typedef struct {
    kind_t       kind;
    op_t         op;
    logic [31:0] req;
    logic [31:0] addr;
  } word_t;

  typedef struct {
    logic [31:0] address;
    status_t     status;
    logic [31:0] used;
    logic [31:0] free;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  op_t         op = OP_ALLOC;
  logic [31:0] request_bytes = '0;
  logic [31:0] free_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] address;
  logic [1:0]  status;
  logic [31:0] used_bytes;
  logic [31:0] free_bytes;
  logic        cfg_we = 1'b0;
  reg_index_t  cfg_index = REG_HEAP_BASE;
  logic [31:0] cfg_wdata = '0;

  first_fit_heap_allocator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .request_bytes(request_bytes), .free_address(free_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .address(address), .status(status), .used_bytes(used_bytes), .free_bytes(free_bytes),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Allocator mirror.
  logic [31:0] heap_base_m;
  logic [31:0] heap_bytes_m;
  logic [31:0] seg_off [NSEG];
  logic [31:0] seg_len [NSEG];
  logic        seg_fr  [NSEG];
  int          seg_cnt;
  logic [31:0] in_use;

  word_t   pending_words[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      no_idle = 1'b0;

  function automatic logic [31:0] payload_of(int i);
    return heap_base_m + seg_off[i] + HDR;
  endfunction

  task automatic rebuild_table();
    for (int i = 0; i < NSEG; i++) begin
      seg_off[i] = '0;
      seg_len[i] = '0;
      seg_fr[i] = 1'b0;
    end
    seg_len[0] = (heap_bytes_m >= HDR) ? heap_bytes_m - HDR : '0;
    seg_fr[0] = 1'b1;
    seg_cnt = 1;
    in_use = '0;
  endtask

  task automatic predict_allocator(input op_t o, input logic [31:0] req,
                                   input logic [31:0] fa);
    result_t r;
    int idx;
    int i;
    logic [63:0] need;
    r.address = '0;
    r.status = ST_DONE;
    idx = -1;
    if (o == OP_ALLOC) begin
      for (i = 0; i < seg_cnt; i++)
        if (idx < 0 && seg_fr[i] && seg_len[i] >= req) idx = i;
      if (idx < 0) begin
        r.status = ST_NOMEM;
      end else begin
        need = {32'b0, req} + HDR + SPLIT_SLACK;
        if ({32'b0, seg_len[idx]} > need && seg_cnt < NSEG) begin
          for (i = seg_cnt; i > idx + 1; i--) begin
            seg_off[i] = seg_off[i-1];
            seg_len[i] = seg_len[i-1];
            seg_fr[i] = seg_fr[i-1];
          end
          seg_off[idx+1] = seg_off[idx] + HDR + req;
          seg_len[idx+1] = seg_len[idx] - req - HDR;
          seg_fr[idx+1] = 1'b1;
          seg_len[idx] = req;
          seg_cnt++;
        end
        seg_fr[idx] = 1'b0;
        in_use = in_use + seg_len[idx] + HDR;
        r.address = payload_of(idx);
      end
    end else if (fa != '0) begin
      for (i = 0; i < seg_cnt; i++)
        if (idx < 0 && payload_of(i) == fa) idx = i;
      if (idx < 0 || seg_fr[idx]) begin
        r.status = ST_INVALID;
      end else begin
        seg_fr[idx] = 1'b1;
        in_use = in_use - seg_len[idx] - HDR;
        i = 0;
        while (i + 1 < seg_cnt) begin
          if (seg_fr[i] && seg_fr[i+1]) begin
            seg_len[i] = seg_len[i] + seg_len[i+1] + HDR;
            for (int j = i + 1; j + 1 < seg_cnt; j++) begin
              seg_off[j] = seg_off[j+1];
              seg_len[j] = seg_len[j+1];
              seg_fr[j] = seg_fr[j+1];
            end
            seg_cnt--;
          end else begin
            i++;
          end
        end
      end
    end
    r.used = in_use;
    r.free = (heap_bytes_m >= in_use) ? heap_bytes_m - in_use : '0;
    expected_results.push_back(r);
  endtask

  // Picks a payload address of an entry in the wanted state, or 0 if none.
  function automatic logic [31:0] pick_address(bit want_free);
    int hits[$];
    for (int i = 0; i < seg_cnt; i++)
      if (seg_fr[i] == want_free) hits.push_back(i);
    if (hits.size() == 0) return '0;
    return payload_of(hits[$urandom_range(0, hits.size() - 1)]);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver.
  int in_gap = 0;
  always @(posedge clk) begin
    word_t w;
    logic  v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (in_valid && in_ready) begin
        predict_allocator(op, request_bytes, free_address);
        in_gap = no_idle ? 0 : $urandom_range(0, 15);
        v = 1'b0;
      end
      if (!v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          case (w.kind)
            K_ALLOC: w.addr = $urandom;
            K_LIVE: w.addr = pick_address(1'b0);
            K_DOUBLE: w.addr = pick_address(1'b1);
            K_RAND: w.addr = $urandom;
            K_NULL: w.addr = '0;
            default: ;
          endcase
          op <= w.op;
          request_bytes <= w.req;
          free_address <= w.addr;
          v = 1'b1;
        end
      end
      in_valid <= v;
    end
  end

  // Monitor.
  int out_stall = 0;
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", address, 32'd0);
        end else begin
          e = expected_results.pop_front();
          if (address !== e.address) report_mismatch("address", address, e.address);
          if (status !== e.status) report_mismatch("status", status, e.status);
          if (used_bytes !== e.used) report_mismatch("used_bytes", used_bytes, e.used);
          if (free_bytes !== e.free) report_mismatch("free_bytes", free_bytes, e.free);
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 15);
      end else if (out_stall > 0) begin
        out_stall--;
      end
      out_ready <= (out_stall == 0);
    end
  end

  task automatic push_word(input kind_t k, input op_t o, input logic [31:0] req,
                           input logic [31:0] fa);
    word_t w;
    w.kind = k;
    w.op = o;
    w.req = req;
    w.addr = fa;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    wait_drained();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HEAP_BASE) heap_base_m = val;
    else heap_bytes_m = val;
    rebuild_table();
  endtask

  task automatic random_phase(input int n, input int max_req);
    int pick;
    logic [31:0] req;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        req = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, max_req);
        push_word(K_ALLOC, OP_ALLOC, req, '0);
      end else if (pick < 85) begin
        push_word(K_LIVE, OP_FREE, $urandom, '0);
      end else if (pick < 91) begin
        push_word(K_DOUBLE, OP_FREE, $urandom, '0);
      end else if (pick < 97) begin
        push_word(K_RAND, OP_FREE, $urandom, '0);
      end else begin
        push_word(K_NULL, OP_FREE, $urandom, '0);
      end
    end
  endtask

  initial begin
    heap_base_m = '0;
    heap_bytes_m = 32'd1048576;
    rebuild_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    push_word(K_FIXED, OP_ALLOC, 32'd0, '0);
    push_word(K_FIXED, OP_ALLOC, 32'hFFFF_FFFF, '0);
    push_word(K_FIXED, OP_FREE, '0, 32'd12);
    push_word(K_FIXED, OP_FREE, '0, 32'd12);
    push_word(K_FIXED, OP_FREE, '0, 32'd0);
    push_word(K_FIXED, OP_FREE, '0, 32'hFFFF_FFFF);
    push_word(K_FIXED, OP_FREE, '0, 32'd13);
    push_word(K_FIXED, OP_ALLOC, 32'd1048564, '0);
    push_word(K_FIXED, OP_ALLOC, 32'd1, '0);
    push_word(K_FIXED, OP_FREE, '0, 32'd12);
    push_word(K_FIXED, OP_ALLOC, 32'd1048536, '0);
    push_word(K_FIXED, OP_ALLOC, 32'd1048537, '0);
    push_word(K_LIVE, OP_FREE, '0, '0);
    push_word(K_FIXED, OP_ALLOC, 32'd100, '0);
    push_word(K_FIXED, OP_ALLOC, 32'd28, '0);
    push_word(K_FIXED, OP_ALLOC, 32'd29, '0);
    push_word(K_LIVE, OP_FREE, '0, '0);
    push_word(K_LIVE, OP_FREE, '0, '0);
    push_word(K_LIVE, OP_FREE, '0, '0);
    random_phase(450, 64);

    write_reg(REG_HEAP_BASE, 32'hFFFF_FFF0);
    write_reg(REG_HEAP_BYTES, 32'd32);
    random_phase(200, 40);

    write_reg(REG_HEAP_BYTES, 32'd5);
    random_phase(60, 4);

    write_reg(REG_HEAP_BASE, 32'h1234_5678);
    write_reg(REG_HEAP_BYTES, 32'hFFFF_FFFF);
    random_phase(450, 1 << 20);

    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_BYTES, 32'd2000);
    random_phase(400, 100);

    write_reg(REG_HEAP_BASE, 32'd0);
    write_reg(REG_HEAP_BYTES, 32'd1048576);
    random_phase(450, 30000);

    wait_drained();
    if (errors == 0) begin
      $display("first_fit_heap_allocator_top test passed");
    end else begin
      $display("first_fit_heap_allocator_top test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("first_fit_heap_allocator_top test failed");
    $finish;
  end

endmodule

// ===== first_fit_heap_allocator_top.f =====
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/first_fit_heap_allocator_top.sv
tb/tb_top.sv
